### hw/rtl/wccm_pkg.sv
// Package for the weighted circular cosine mean block.
// Holds sizes, command codes, the state enum and the CORDIC arctangent table.
`default_nettype none
package wccm_pkg;
    localparam int COMPONENTS = 8;
    localparam int FEATURES = 8;
    localparam int SAMPLE_COUNT_BITS = 20;
    localparam int CELLS = COMPONENTS * FEATURES;
    localparam int CELL_BITS = $clog2(CELLS);
    localparam int COMP_BITS = $clog2(COMPONENTS);
    localparam int FEAT_BITS = $clog2(FEATURES);
    localparam int NUM_BITS = 32 + SAMPLE_COUNT_BITS;
    localparam int DEN_BITS = 16 + SAMPLE_COUNT_BITS;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN = 652032874;
    localparam int QBITS = 16;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ACC = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_RMW,
        ST_FREAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    function automatic logic [13:0] arc_value(input logic [3:0] i);
        logic [13:0] v;
        begin
            case (i)
                4'd0: v = 14'd8192;
                4'd1: v = 14'd4836;
                4'd2: v = 14'd2555;
                4'd3: v = 14'd1297;
                4'd4: v = 14'd651;
                4'd5: v = 14'd326;
                4'd6: v = 14'd163;
                4'd7: v = 14'd81;
                4'd8: v = 14'd41;
                4'd9: v = 14'd20;
                4'd10: v = 14'd10;
                4'd11: v = 14'd5;
                4'd12: v = 14'd3;
                4'd13: v = 14'd1;
                4'd14: v = 14'd1;
                default: v = 14'd0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

### hw/rtl/wccm_if.sv
// Valid/ready channel interfaces for the input and result streams.
// Depends on nothing.
`default_nettype none
interface wccm_in_if;
    logic valid;
    logic ready;
    logic [1:0] command;
    logic [2:0] component;
    logic [2:0] feature;
    logic signed [15:0] angle;
    logic [15:0] weight;
    modport source (output valid, command, component, feature, angle, weight, input ready);
    modport sink (input valid, command, component, feature, angle, weight, output ready);
endinterface

interface wccm_out_if;
    logic valid;
    logic ready;
    logic [2:0] out_component;
    logic [2:0] out_feature;
    logic signed [15:0] ratio;
    logic zero_weight;
    logic last;
    modport source (output valid, out_component, out_feature, ratio, zero_weight, last,
                    input ready);
    modport sink (input valid, out_component, out_feature, ratio, zero_weight, last,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/wccm_ram.sv
// Generic single-port-write, one-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module wccm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/wccm_cordic.sv
// Iterative CORDIC cosine of a binary angle difference, one step a cycle.
// Depends on wccm_pkg.
`default_nettype none
module wccm_cordic
    import wccm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic [15:0] diff,
    output logic done,
    output logic signed [16:0] cosine
);
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [16:0] z_reg, z_next;
    logic [3:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic neg_reg, neg_next;
    logic [15:0] mag;
    logic signed [33:0] c;

    always_comb
    begin
        mag = diff[15] ? 16'(17'h10000 - {1'b0, diff}) : diff;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        if (start)
        begin
            neg_next = mag > 16'd16384;
            z_next = neg_next ? 17'(17'd32768 - {1'b0, mag}) : 17'({1'b0, mag});
            x_next = 34'(CORDIC_GAIN);
            y_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[16])
            begin
                x_next = x_reg - (y_reg >>> step_reg);
                y_next = y_reg + (x_reg >>> step_reg);
                z_next = z_reg - 17'(arc_value(step_reg));
            end
            else
            begin
                x_next = x_reg + (y_reg >>> step_reg);
                y_next = y_reg - (x_reg >>> step_reg);
                z_next = z_reg + 17'(arc_value(step_reg));
            end
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        c = (x_reg + 34'sd16384) >>> 15;
        if (c > 34'sd32767)
        begin
            c = 34'sd32767;
        end
        else if (c < -34'sd32767)
        begin
            c = -34'sd32767;
        end
        cosine = neg_reg ? -17'(c) : 17'(c);
        done = !busy_reg && !start;
    end
endmodule
`default_nettype wire

### hw/rtl/wccm_div.sv
// Restoring divider: rounded numerator magnitude over denominator, one bit a cycle.
// Depends on wccm_pkg.
`default_nettype none
module wccm_div
    import wccm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic [NUM_BITS-1:0] dividend,
    input wire logic [DEN_BITS-1:0] divisor,
    output logic busy,
    output logic [NUM_BITS:0] quotient
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 2);
    logic [NUM_BITS:0] q_reg, q_next;
    logic [DEN_BITS:0] r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg, d_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [DEN_BITS+1:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = '0;
        if (start)
        begin
            // Dividend is mag + den/2; it fits in NUM_BITS+1 bits.
            q_next = {1'b0, dividend} + (NUM_BITS + 1)'(divisor >> 1);
            r_next = '0;
            d_next = divisor;
            cnt_next = CNT_BITS'(NUM_BITS + 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[NUM_BITS]} - {2'b00, d_reg};
            if (!trial[DEN_BITS+1])
            begin
                r_next = trial[DEN_BITS:0];
                q_next = {q_reg[NUM_BITS-1:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS]};
                q_next = {q_reg[NUM_BITS-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

### hw/rtl/weighted_circular_cosine_mean.sv
// Load: a mean write. Accumulate: mean read, 16 CORDIC steps, read-modify-write.
// Finish: per cell a read, a 53-step divide and an emit, plus any output stalls.
// One item in flight at a time; input ready only while idle.
// After reset the accumulators read as zero: a valid bit per cell clears at once.
// Depends on wccm_pkg, wccm_if, wccm_ram, wccm_cordic and wccm_div.
`default_nettype none
module weighted_circular_cosine_mean
    import wccm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    wccm_in_if.sink in_ch,
    wccm_out_if.source out_ch
);
    localparam logic signed [NUM_BITS-1:0] NUM_MAX = {1'b0, {(NUM_BITS-1){1'b1}}};
    localparam logic signed [NUM_BITS-1:0] NUM_MIN = {1'b1, {(NUM_BITS-1){1'b0}}};

    state_t state_reg, state_next;
    logic [CELL_BITS-1:0] cell_reg, cell_next;
    logic signed [15:0] angle_reg;
    logic [15:0] weight_reg;
    logic [CELLS-1:0] valid_reg, valid_next;
    logic [CELL_BITS-1:0] addr;
    logic mean_we, acc_we;
    logic [15:0] mean_rd;
    logic [NUM_BITS+DEN_BITS-1:0] acc_rd, acc_wd;
    logic signed [NUM_BITS-1:0] num_cur;
    logic [DEN_BITS-1:0] den_cur;
    logic cordic_start, cordic_done, div_start, div_busy;
    logic signed [16:0] cosine;
    logic signed [NUM_BITS+1:0] sum_wide;
    logic [DEN_BITS:0] den_wide;
    logic [NUM_BITS:0] quotient;
    logic [NUM_BITS-1:0] num_mag;
    logic signed [NUM_BITS-1:0] num_hold_reg;
    logic signed [16:0] ratio_s;
    logic [CELL_BITS-1:0] ridx;
    logic in_fire, out_fire, first_reg, first_next, legal;
    logic [15:0] ratio_reg;
    logic zw_reg;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign legal = ({3'b000, in_ch.component} < 6'(COMPONENTS))
                && ({3'b000, in_ch.feature} < 6'(FEATURES));
    assign ridx = CELL_BITS'(in_ch.component * FEATURES + in_ch.feature);

    wccm_ram #(.WIDTH(16), .DEPTH(CELLS)) u_mean (
        .clk(clk), .we(mean_we), .waddr(ridx), .wdata(in_ch.angle),
        .raddr(ridx), .rdata(mean_rd)
    );
    wccm_ram #(.WIDTH(NUM_BITS + DEN_BITS), .DEPTH(CELLS)) u_acc (
        .clk(clk), .we(acc_we), .waddr(cell_reg), .wdata(acc_wd),
        .raddr(addr), .rdata(acc_rd)
    );
    wccm_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cordic_start),
        .diff(16'(angle_reg - mean_rd)), .done(cordic_done), .cosine(cosine)
    );
    wccm_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(num_mag),
        .divisor(den_cur), .busy(div_busy), .quotient(quotient)
    );

    // Unwritten cells read as zero accumulators.
    assign num_cur = valid_reg[cell_reg] ? acc_rd[NUM_BITS+DEN_BITS-1:DEN_BITS] : '0;
    assign den_cur = valid_reg[cell_reg] ? acc_rd[DEN_BITS-1:0] : '0;
    assign num_mag = num_cur[NUM_BITS-1] ? NUM_BITS'(-num_cur) : NUM_BITS'(num_cur);

    always_comb
    begin
        sum_wide = (NUM_BITS+2)'(num_cur) + (NUM_BITS+2)'($signed({1'b0, weight_reg}) * cosine);
        den_wide = {1'b0, den_cur} + (DEN_BITS+1)'(weight_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cell_next = cell_reg;
        first_next = first_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cell_next = ridx;
                    if (in_ch.command == CMD_ACC && legal)
                    begin
                        state_next = ST_CORDIC;
                        first_next = 1'b1;
                    end
                    else if (in_ch.command == CMD_FINISH)
                    begin
                        cell_next = '0;
                        state_next = ST_FREAD;
                    end
                end
            end
            ST_CORDIC:
            begin
                first_next = 1'b0;
                if (!first_reg && cordic_done)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW: state_next = ST_IDLE;
            ST_FREAD:
            begin
                state_next = ST_DIV;
                first_next = 1'b1;
            end
            ST_DIV:
            begin
                first_next = 1'b0;
                if (!first_reg && !div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    if (cell_reg == CELL_BITS'(CELLS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cell_next = cell_reg + 1'b1;
                        state_next = ST_FREAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and memory controls.
    always_comb
    begin
        in_ch.ready = state_reg == ST_IDLE;
        mean_we = in_fire && in_ch.command == CMD_LOAD && legal;
        cordic_start = state_reg == ST_CORDIC && first_reg;
        div_start = state_reg == ST_DIV && first_reg;
        addr = (state_reg == ST_IDLE) ? ridx : cell_reg;
        acc_we = 1'b0;
        acc_wd = '0;
        valid_next = valid_reg;
        if (state_reg == ST_RMW)
        begin
            acc_we = 1'b1;
            valid_next[cell_reg] = 1'b1;
            acc_wd[DEN_BITS-1:0] = den_wide[DEN_BITS] ? '1 : den_wide[DEN_BITS-1:0];
            if (sum_wide > (NUM_BITS+2)'(NUM_MAX))
            begin
                acc_wd[NUM_BITS+DEN_BITS-1:DEN_BITS] = NUM_MAX;
            end
            else if (sum_wide < (NUM_BITS+2)'(NUM_MIN))
            begin
                acc_wd[NUM_BITS+DEN_BITS-1:DEN_BITS] = NUM_MIN;
            end
            else
            begin
                acc_wd[NUM_BITS+DEN_BITS-1:DEN_BITS] = NUM_BITS'(sum_wide);
            end
        end
        if (state_reg == ST_EMIT && out_fire)
        begin
            valid_next[cell_reg] = 1'b0;
        end
        out_ch.valid = state_reg == ST_EMIT;
        out_ch.out_component = 3'(cell_reg / FEATURES);
        out_ch.out_feature = 3'(cell_reg % FEATURES);
        out_ch.ratio = ratio_reg;
        out_ch.zero_weight = zw_reg;
        out_ch.last = cell_reg == CELL_BITS'(CELLS - 1);
    end

    always_comb
    begin
        ratio_s = (quotient > (NUM_BITS+1)'(32768)) ? 17'sd32768
                  : 17'($signed({1'b0, quotient[15:0]}))
                  | ((quotient == (NUM_BITS+1)'(32768)) ? 17'sd32768 : 17'sd0);
        if (num_hold_reg[NUM_BITS-1])
        begin
            ratio_s = -ratio_s;
        end
        if (ratio_s > 17'sd32767)
        begin
            ratio_s = 17'sd32767;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cell_reg <= '0;
            first_reg <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cell_reg <= cell_next;
            first_reg <= first_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            angle_reg <= in_ch.angle;
            weight_reg <= in_ch.weight;
        end
        if (state_reg == ST_DIV && first_reg)
        begin
            num_hold_reg <= num_cur;
            zw_reg <= (den_cur == '0);
        end
        if (state_reg == ST_DIV && !first_reg && !div_busy)
        begin
            ratio_reg <= zw_reg ? 16'd0 : 16'(ratio_s);
        end
    end
endmodule
`default_nettype wire

### hw/rtl/wccm_checker.sv
// Port-level assertions for the weighted circular cosine mean block, bound to the top.
// Depends on the top level it binds to.
`default_nettype none
module wccm_port_checks (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [15:0] ratio,
    input wire logic zero_weight,
    input wire logic last
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken during emit");
    a_zero_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_weight |-> ratio == 16'd0) else $error("zero weight ratio");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ratio)) else $error("result dropped");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid) else $error("emit past last");
endmodule

bind weighted_circular_cosine_mean wccm_port_checks u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .ratio(out_ch.ratio),
    .zero_weight(out_ch.zero_weight), .last(out_ch.last)
);
`default_nettype wire
